[rtl/core/gps_pkg.sv]
package gps_pkg;

    localparam int FRACTION_BITS = 16;

    // log word holds ((leading zeros + 1) << FRACTION_BITS) - log fraction
    localparam int LG_W  = FRACTION_BITS + 5;
    localparam int EXP_W = FRACTION_BITS + 9;
    localparam int K_W   = EXP_W - FRACTION_BITS;

    localparam int DIV_STAGES = 64;
    localparam int DEN_LAT    = 2;
    localparam int LOG_LAT    = FRACTION_BITS + 1;
    localparam int EXP_LAT    = FRACTION_BITS + 2;
    localparam int ALIGN_LAT  = LOG_LAT + EXP_LAT - DEN_LAT;
    localparam int LATENCY    = LOG_LAT + EXP_LAT + 2 * DIV_STAGES + 6;

    localparam logic [1:0] REG_P_SOLID      = 2'd0;
    localparam logic [1:0] REG_BETA         = 2'd1;
    localparam logic [1:0] REG_EPS          = 2'd2;
    localparam logic [1:0] REG_ALPHA_PACKED = 2'd3;

    // side words that ride along a divider pipe
    typedef struct packed {
        logic        sat;
        logic [63:0] w0;
        logic [63:0] w1;
    } t_div_tag;

    function automatic logic [63:0] isqrt64(input logic [63:0] x);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] one;
        rem = x;
        res = '0;
        one = 64'h4000_0000_0000_0000;
        for (int j = 0; j < 32; j++) begin
            if (rem >= res + one) begin
                rem = rem - (res + one);
                res = (res >> 1) + one;
            end else begin
                res = res >> 1;
            end
            one = one >> 2;
        end
        return res;
    endfunction

    // 2^32 * 2^(-2^-idx), evaluated at elaboration only
    function automatic logic [31:0] gps_root(input int idx);
        logic [31:0] c;
        logic [63:0] sq;
        c = 32'h8000_0000;
        for (int j = 0; j < idx; j++) begin
            sq = isqrt64({c, 32'h0});
            c  = sq[31:0];
        end
        return c;
    endfunction

endpackage

[rtl/core/gps_denom.sv]
module gps_denom
    import gps_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [15:0] i_alpha,
    input  logic [31:0] i_eps,
    input  logic [15:0] i_alpha_packed,
    output logic        o_valid,
    output logic [15:0] o_alpha,
    output logic [32:0] o_den
);

    logic [15:0] n_diff;
    logic [16:0] n_rest;
    logic [48:0] n_eps_prod;
    logic [32:0] n_dp;
    logic [32:0] n_de;
    logic [32:0] n_den;

    logic        r_v1;
    logic [15:0] r_diff;
    logic [48:0] r_eps_prod;
    logic [15:0] r_alpha1;
    logic        r_v2;
    logic [15:0] r_alpha2;
    logic [32:0] r_den;

    always_comb begin
        n_diff     = (i_alpha_packed > i_alpha) ? (i_alpha_packed - i_alpha) : 16'd0;
        n_rest     = 17'h1_0000 - {1'b0, i_alpha};
        n_eps_prod = 49'(i_eps) * 49'(n_rest);
    end

    always_comb begin
        n_dp  = {1'b0, r_diff, 16'h0};
        n_de  = r_eps_prod[48:16];
        n_den = (n_dp > n_de) ? n_dp : n_de;
        if (n_den == '0) begin
            n_den = 33'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_diff     <= n_diff;
        r_eps_prod <= n_eps_prod;
        r_alpha1   <= i_alpha;
        r_alpha2   <= r_alpha1;
        r_den      <= n_den;
    end

    assign o_valid = r_v2;
    assign o_alpha = r_alpha2;
    assign o_den   = r_den;

endmodule

[rtl/core/gps_log.sv]
module gps_log
    import gps_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic [15:0]              i_alpha,
    output logic                     o_valid,
    output logic [3:0]               o_lz,
    output logic [FRACTION_BITS-1:0] o_frac
);

    logic [3:0]  n_lz;
    logic [15:0] n_norm;

    logic                     r_v    [0:FRACTION_BITS];
    logic [30:0]              r_m    [0:FRACTION_BITS];
    logic [3:0]               r_lz   [0:FRACTION_BITS];
    logic [FRACTION_BITS-1:0] r_frac [0:FRACTION_BITS];

    // leading zero count, the highest set bit wins
    always_comb begin
        n_lz = 4'd0;
        for (int b = 0; b < 16; b++) begin
            if (i_alpha[b]) begin
                n_lz = 4'(15 - b);
            end
        end
        n_norm = i_alpha << n_lz;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m[0]    <= {n_norm, 15'h0};
        r_lz[0]   <= n_lz;
        r_frac[0] <= '0;
    end

    // one squaring per stage yields one fraction bit of the log
    for (genvar i = 1; i <= FRACTION_BITS; i++) begin : g_sq
        logic [61:0] sq_full;
        logic [31:0] sq;
        logic [30:0] m_next;

        always_comb begin
            sq_full = 62'(r_m[i-1]) * 62'(r_m[i-1]);
            sq      = sq_full[61:30];
            m_next  = sq[31] ? sq[31:1] : sq[30:0];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i] <= 1'b0;
            end else begin
                r_v[i] <= r_v[i-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_m[i]    <= m_next;
            r_lz[i]   <= r_lz[i-1];
            r_frac[i] <= {r_frac[i-1][FRACTION_BITS-2:0], sq[31]};
        end
    end

    assign o_valid = r_v[FRACTION_BITS];
    assign o_lz    = r_lz[FRACTION_BITS];
    assign o_frac  = r_frac[FRACTION_BITS];

endmodule

[rtl/core/gps_exp.sv]
module gps_exp
    import gps_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic [3:0]               i_lz,
    input  logic [FRACTION_BITS-1:0] i_frac,
    input  logic [15:0]              i_beta,
    output logic                     o_valid,
    output logic [32:0]              o_pow
);

    logic [LG_W-1:0]      n_lg;
    logic [LG_W+15:0]     n_e_full;
    logic [EXP_W-1:0]     n_e;
    logic [32:0]          n_pow;

    logic                     r_v [0:FRACTION_BITS];
    logic [K_W-1:0]           r_k [0:FRACTION_BITS];
    logic [FRACTION_BITS-1:0] r_f [0:FRACTION_BITS];
    logic [32:0]              r_p [0:FRACTION_BITS];
    logic                     r_out_v;
    logic [32:0]              r_pow;

    always_comb begin
        n_lg     = ((LG_W'(i_lz) + LG_W'(1)) << FRACTION_BITS) - LG_W'(i_frac);
        n_e_full = (LG_W + 16)'(n_lg) * (LG_W + 16)'(i_beta);
        n_e      = n_e_full[LG_W+15:12];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k[0] <= n_e[EXP_W-1:FRACTION_BITS];
        r_f[0] <= n_e[FRACTION_BITS-1:0];
        r_p[0] <= 33'h1_0000_0000;
    end

    // fraction bit F-i selects the root 2^(-2^-i)
    for (genvar i = 1; i <= FRACTION_BITS; i++) begin : g_mul
        localparam logic [31:0] C_ROOT = gps_root(i);
        logic [64:0] prod;

        always_comb begin
            prod = 65'(r_p[i-1]) * 65'(C_ROOT);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i] <= 1'b0;
            end else begin
                r_v[i] <= r_v[i-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_k[i] <= r_k[i-1];
            r_f[i] <= r_f[i-1];
            r_p[i] <= r_f[i-1][FRACTION_BITS-i] ? prod[64:32] : r_p[i-1];
        end
    end

    always_comb begin
        if (r_k[FRACTION_BITS] > K_W'(32)) begin
            n_pow = '0;
        end else begin
            n_pow = r_p[FRACTION_BITS] >> r_k[FRACTION_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= r_v[FRACTION_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_pow <= n_pow;
    end

    assign o_valid = r_out_v;
    assign o_pow   = r_pow;

endmodule

[rtl/core/gps_div.sv]
module gps_div
    import gps_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [32:0] i_rem,
    input  logic [63:0] i_quo,
    input  logic [32:0] i_den,
    input  t_div_tag    i_tag,
    output logic        o_valid,
    output logic [63:0] o_quo,
    output t_div_tag    o_tag
);

    logic        r_v   [0:DIV_STAGES-1];
    logic [32:0] r_rem [0:DIV_STAGES-1];
    logic [63:0] r_quo [0:DIV_STAGES-1];
    logic [32:0] r_den [0:DIV_STAGES-1];
    t_div_tag    r_tag [0:DIV_STAGES-1];

    // one restoring step per stage: dividend bits leave at the top of the
    // word while quotient bits enter at the bottom
    for (genvar j = 0; j < DIV_STAGES; j++) begin : g_step
        logic        p_v;
        logic [32:0] p_rem;
        logic [63:0] p_quo;
        logic [32:0] p_den;
        t_div_tag    p_tag;
        logic [33:0] trial;
        logic        take;
        logic [33:0] diff;

        if (j == 0) begin : g_first
            assign p_v   = i_valid;
            assign p_rem = i_rem;
            assign p_quo = i_quo;
            assign p_den = i_den;
            assign p_tag = i_tag;
        end else begin : g_next
            assign p_v   = r_v[j-1];
            assign p_rem = r_rem[j-1];
            assign p_quo = r_quo[j-1];
            assign p_den = r_den[j-1];
            assign p_tag = r_tag[j-1];
        end

        always_comb begin
            trial = {p_rem, p_quo[63]};
            take  = (trial >= {1'b0, p_den});
            diff  = trial - {1'b0, p_den};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else begin
                r_v[j] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[j] <= take ? diff[32:0] : trial[32:0];
            r_quo[j] <= {p_quo[62:0], take};
            r_den[j] <= p_den;
            r_tag[j] <= p_tag;
        end
    end

    assign o_valid = r_v[DIV_STAGES-1];
    assign o_quo   = r_quo[DIV_STAGES-1];
    assign o_tag   = r_tag[DIV_STAGES-1];

endmodule

[rtl/core/granular_particle_stress_core.sv]
// granular particle stress pipeline
// one volume fraction word in, one stress / slope / saturation word out.
// input: drive i_alpha with i_start high; the word is taken at a rising edge
//   where i_start is high and o_busy is low. o_busy is low whenever reset is
//   released, so a new word may be started in every cycle.
// output: o_valid is high for one cycle with o_stress, o_stress_slope and
//   o_saturated; the receiver must take the word in that cycle.
// path: from the accepting edge to the cycle in which o_valid is high, a word
//   passes the log squaring chain, the exp root chain, and two 64-stage
//   one-bit-per-stage dividers in series.
// throughput: one word per cycle, every stage is pipelined.
// configuration: i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data;
//   index 0 p_solid, 1 beta, 2 eps, 3 alpha_packed. Write only while no word
//   is in flight.
// reset: synchronous active low; configuration registers return to defaults
//   and every word in flight is dropped.
module granular_particle_stress_core
    import gps_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [15:0] i_alpha,
    output logic        o_valid,
    output logic [63:0] o_stress,
    output logic [63:0] o_stress_slope,
    output logic        o_saturated,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    logic [31:0] r_p_solid;
    logic [15:0] r_beta;
    logic [31:0] r_eps;
    logic [15:0] r_alpha_packed;

    logic        r_in_v;
    logic [15:0] r_in_alpha;
    logic        r_al_v [0:ALIGN_LAT-1];
    logic [15:0] r_al_a [0:ALIGN_LAT-1];

    logic                     log_v;
    logic [3:0]               log_lz;
    logic [FRACTION_BITS-1:0] log_frac;
    logic                     exp_v;
    logic [32:0]              exp_pow;
    logic                     den_v;
    logic [15:0]              den_alpha;
    logic [32:0]              den_d;

    logic [32:0] n_pow_eff;
    logic [64:0] n_prod;
    logic        r_x_v;
    logic [63:0] r_x_prod;
    logic [32:0] r_x_pow;
    logic [32:0] r_x_den;
    logic [15:0] r_x_alpha;

    logic        n_sat1;
    logic [32:0] n_sd_rem;
    logic [63:0] n_sd_quo;
    logic [32:0] n_sd_den;
    t_div_tag    n_sd_tag;
    logic        n_az;
    logic [63:0] n_td_quo;
    logic [32:0] n_td_den;
    t_div_tag    n_td_tag;

    logic        sd_v;
    logic [63:0] sd_quo;
    t_div_tag    sd_tag;
    logic        td_v;
    logic [63:0] td_quo;

    logic [64:0] n_t_full;
    logic        r_z_v;
    logic [63:0] r_z_s;
    logic [32:0] r_z_den;
    logic        r_z_sat;
    logic [51:0] r_z_t;

    logic        r_w_v;
    logic [63:0] r_w_lo;
    logic [63:0] r_w_m1;
    logic [51:0] r_w_m2;
    logic [51:0] r_w_hi;
    logic [63:0] r_w_s;
    logic [32:0] r_w_den;
    logic        r_w_sat;

    logic [33:0] n_mid;
    logic [63:0] n_high;
    logic        n_sat_m;
    logic        r_v_v;
    logic [63:0] r_v_s1;
    logic [63:0] r_v_s;
    logic [32:0] r_v_den;
    logic        r_v_sat;

    logic        n_sat2;
    logic [32:0] n_s2_rem;
    logic [63:0] n_s2_quo;
    logic [32:0] n_s2_den;
    t_div_tag    n_s2_tag;
    logic        s2_v;
    logic [63:0] s2_quo;
    t_div_tag    s2_tag;

    logic [64:0] n_sum;
    logic        r_out_v;
    logic [63:0] r_out_s;
    logic [63:0] r_out_slope;
    logic        r_out_sat;

    assign o_busy      = ~i_rst_n;
    assign o_cfg_ready = i_rst_n;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_solid      <= 32'd327680;
            r_beta         <= 16'd12288;
            r_eps          <= 32'd429;
            r_alpha_packed <= 16'd39322;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_P_SOLID:      r_p_solid      <= i_cfg_data;
                REG_BETA:         r_beta         <= i_cfg_data[15:0];
                REG_EPS:          r_eps          <= i_cfg_data;
                REG_ALPHA_PACKED: r_alpha_packed <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // input word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else begin
            r_in_v <= i_start && !o_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_alpha <= i_alpha;
    end

    // alpha waits here so the denominator lands next to the power
    for (genvar j = 0; j < ALIGN_LAT; j++) begin : g_align
        if (j == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_al_v[j] <= 1'b0;
                end else begin
                    r_al_v[j] <= r_in_v;
                end
            end
            always_ff @(posedge i_clk) begin
                r_al_a[j] <= r_in_alpha;
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_al_v[j] <= 1'b0;
                end else begin
                    r_al_v[j] <= r_al_v[j-1];
                end
            end
            always_ff @(posedge i_clk) begin
                r_al_a[j] <= r_al_a[j-1];
            end
        end
    end

    gps_log u_log (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_v),
        .i_alpha (r_in_alpha),
        .o_valid (log_v),
        .o_lz    (log_lz),
        .o_frac  (log_frac)
    );

    gps_exp u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (log_v),
        .i_lz    (log_lz),
        .i_frac  (log_frac),
        .i_beta  (r_beta),
        .o_valid (exp_v),
        .o_pow   (exp_pow)
    );

    gps_denom u_denom (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (r_al_v[ALIGN_LAT-1]),
        .i_alpha        (r_al_a[ALIGN_LAT-1]),
        .i_eps          (r_eps),
        .i_alpha_packed (r_alpha_packed),
        .o_valid        (den_v),
        .o_alpha        (den_alpha),
        .o_den          (den_d)
    );

    // power with the zero fraction case, then p_solid * power
    always_comb begin
        if (den_alpha == '0) begin
            n_pow_eff = (r_beta == '0) ? 33'h1_0000_0000 : 33'd0;
        end else begin
            n_pow_eff = exp_pow;
        end
        n_prod = 65'(r_p_solid) * 65'(n_pow_eff);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_v <= 1'b0;
        end else begin
            r_x_v <= exp_v && den_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x_prod  <= n_prod[63:0];
        r_x_pow   <= n_pow_eff;
        r_x_den   <= den_d;
        r_x_alpha <= den_alpha;
    end

    // stress divide: quotient of prod * 2^8 / d overflows 64 bits exactly
    // when prod >> 56 reaches d; then the divider is fed a pass-through of ones
    always_comb begin
        n_sat1   = {25'h0, r_x_prod[63:56]} >= r_x_den;
        n_sd_rem = n_sat1 ? 33'd0 : {25'h0, r_x_prod[63:56]};
        n_sd_quo = n_sat1 ? '1 : {r_x_prod[55:0], 8'h0};
        n_sd_den = n_sat1 ? 33'd1 : r_x_den;
        n_sd_tag.sat = n_sat1;
        n_sd_tag.w0  = {31'h0, r_x_den};
        n_sd_tag.w1  = '0;

        n_az     = (r_x_alpha == '0);
        n_td_quo = n_az ? 64'd0 : {15'h0, r_x_pow, 16'h0};
        n_td_den = n_az ? 33'd1 : {17'h0, r_x_alpha};
        n_td_tag = '0;
    end

    gps_div u_div_stress (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_x_v),
        .i_rem   (n_sd_rem),
        .i_quo   (n_sd_quo),
        .i_den   (n_sd_den),
        .i_tag   (n_sd_tag),
        .o_valid (sd_v),
        .o_quo   (sd_quo),
        .o_tag   (sd_tag)
    );

    gps_div u_div_ratio (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_x_v),
        .i_rem   (33'd0),
        .i_quo   (n_td_quo),
        .i_den   (n_td_den),
        .i_tag   (n_td_tag),
        .o_valid (td_v),
        .o_quo   (td_quo),
        .o_tag   ()
    );

    always_comb begin
        n_t_full = 65'(td_quo[48:0]) * 65'(r_beta);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_z_v <= 1'b0;
            r_w_v <= 1'b0;
            r_v_v <= 1'b0;
        end else begin
            r_z_v <= sd_v && td_v;
            r_w_v <= r_z_v;
            r_v_v <= r_w_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_z_s   <= sd_tag.sat ? '1 : sd_quo;
        r_z_den <= sd_tag.w0[32:0];
        r_z_sat <= sd_tag.sat;
        r_z_t   <= n_t_full[63:12];
    end

    // stress * T / 2^32 as four partial products
    always_ff @(posedge i_clk) begin
        r_w_lo  <= 64'(r_z_s[31:0]) * 64'(r_z_t[31:0]);
        r_w_m1  <= 64'(r_z_s[63:32]) * 64'(r_z_t[31:0]);
        r_w_m2  <= 52'(r_z_s[31:0]) * 52'(r_z_t[51:32]);
        r_w_hi  <= 52'(r_z_s[63:32]) * 52'(r_z_t[51:32]);
        r_w_s   <= r_z_s;
        r_w_den <= r_z_den;
        r_w_sat <= r_z_sat;
    end

    always_comb begin
        n_mid   = 34'(r_w_lo[63:32]) + 34'(r_w_m1[31:0]) + 34'(r_w_m2[31:0]);
        n_high  = 64'(r_w_hi) + 64'(r_w_m1[63:32]) + 64'(r_w_m2[51:32])
                + 64'(n_mid[33:32]);
        n_sat_m = (n_high[63:32] != '0);
    end

    always_ff @(posedge i_clk) begin
        r_v_s1  <= n_sat_m ? '1 : {n_high[31:0], n_mid[31:0]};
        r_v_s   <= r_w_s;
        r_v_den <= r_w_den;
        r_v_sat <= r_w_sat | n_sat_m;
    end

    // stress * 2^32 / d, same overflow rule with a shift of 32
    always_comb begin
        n_sat2   = {1'b0, r_v_s[63:32]} >= r_v_den;
        n_s2_rem = n_sat2 ? 33'd0 : {1'b0, r_v_s[63:32]};
        n_s2_quo = n_sat2 ? '1 : {r_v_s[31:0], 32'h0};
        n_s2_den = n_sat2 ? 33'd1 : r_v_den;
        n_s2_tag.sat = r_v_sat | n_sat2;
        n_s2_tag.w0  = r_v_s1;
        n_s2_tag.w1  = r_v_s;
    end

    gps_div u_div_slope (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v_v),
        .i_rem   (n_s2_rem),
        .i_quo   (n_s2_quo),
        .i_den   (n_s2_den),
        .i_tag   (n_s2_tag),
        .o_valid (s2_v),
        .o_quo   (s2_quo),
        .o_tag   (s2_tag)
    );

    always_comb begin
        n_sum = 65'(s2_tag.w0) + 65'(s2_quo);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_s     <= s2_tag.w1;
        r_out_slope <= n_sum[64] ? '1 : n_sum[63:0];
        r_out_sat   <= s2_tag.sat | n_sum[64];
    end

    assign o_valid        = r_out_v;
    assign o_stress       = r_out_s;
    assign o_stress_slope = r_out_slope;
    assign o_saturated    = r_out_sat;

    // every started word comes out after the fixed latency
    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##LATENCY o_valid)
        else $error("result word missing after pipeline latency");

    // reset flushes the pipe
    a_reset_flush : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result word right after reset");

    // d never exceeds 1.0, so without clipping the slope is at least the stress
    a_slope_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_saturated) |-> (o_stress_slope >= o_stress))
        else $error("slope below stress without saturation");

endmodule
